// File: src/rapc_pkg.sv
// Shared types, constants and helpers for the rotate-add packet checker.
package rapc_pkg;

   // Packet layout
   localparam int unsigned LEN_POS  = 2;
   localparam int unsigned DATA_POS = 3;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 9;

   localparam logic [BYTE_W-1:0] TOP_BIT  = 8'h80;
   localparam logic [BYTE_W-1:0] WILDCARD = 8'hDE;

   // Largest legal length byte
   localparam logic [BYTE_W-1:0] MAX_LEN  = BYTE_W'(255 - DATA_POS);
   localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
   localparam logic [POS_W-1:0]  LEN_AT   = POS_W'(LEN_POS);
   localparam logic [POS_W-1:0]  DATA_AT  = POS_W'(DATA_POS);

   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              first;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] running_sum;
      logic              check_seen;
      logic              packet_good;
      logic              length_bad;
   } rsp_word_type;

   // Rotate the sum left by one, then add the byte modulo 256
   function automatic logic [BYTE_W-1:0] rot_add(input logic [BYTE_W-1:0] s,
                                                 input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = {s[BYTE_W-2:0], ((s & TOP_BIT) != '0)};
      return r + b;
   endfunction

endpackage

// File: src/rapc_engine.sv
// Packet state registers and the combinational checksum/check step.
module rapc_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  rapc_pkg::req_word_type word_in,
   output rapc_pkg::rsp_word_type word_out
);
   import rapc_pkg::*;

   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic              busy_ff, busy_in;

   logic [BYTE_W-1:0] cur_sum;
   logic [POS_W-1:0]  cur_pos;
   logic [BYTE_W-1:0] cur_len;
   logic              cur_busy;
   logic [POS_W-1:0]  chk_pos;
   logic              at_check;

   // Start of packet clears the working state before the byte is applied
   always_comb begin
      cur_sum  = word_in.first ? '0 : sum_ff;
      cur_pos  = word_in.first ? '0 : pos_ff;
      cur_len  = word_in.first ? '0 : len_ff;
      cur_busy = word_in.first | busy_ff;
      chk_pos  = DATA_AT + POS_W'(cur_len);
      at_check = (cur_pos > LEN_AT) && (cur_pos >= chk_pos);
   end

   // Next state and result word
   always_comb begin
      sum_in   = cur_sum;
      pos_in   = cur_pos;
      len_in   = cur_len;
      busy_in  = cur_busy;
      word_out = '0;
      word_out.running_sum = cur_sum;
      if (cur_busy) begin
         if (at_check) begin
            word_out.check_seen  = 1'b1;
            word_out.packet_good = (word_in.byte_in == cur_sum) ||
                                   (word_in.byte_in == WILDCARD);
            busy_in = 1'b0;
         end else begin
            sum_in = rot_add(cur_sum, word_in.byte_in);
            word_out.running_sum = sum_in;
            if (cur_pos == LEN_AT) begin
               len_in = word_in.byte_in;
               if (word_in.byte_in > MAX_LEN) begin
                  word_out.length_bad = 1'b1;
                  busy_in = 1'b0;
               end
            end
            if (cur_pos != POS_MAX) begin
               pos_in = cur_pos + POS_W'(1);
            end
         end
      end
   end

   // Advance state once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         pos_ff  <= '0;
         len_ff  <= '0;
         busy_ff <= 1'b0;
      end else if (step) begin
         sum_ff  <= sum_in;
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// File: src/rotate_add_packet_checker_top.sv
// Top level: input register, checksum engine and result register.
// Accepts one packet byte per clock while the output is not stalled and returns
// exactly one result word per byte, via the input register and then the result
// register. The rate is set by the combinational rotate-add and position compare
// between the input register and the result register; the input register takes
// a new word whenever the result register is free or being drained in that cycle.
// Each result carries the running checksum, so the block doubles as a
// checksum generator. There are no configuration registers.
module rotate_add_packet_checker_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rapc_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rapc_pkg::rsp_word_type rsp_data
);
   import rapc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   rsp_word_type step_word;
   logic         out_free;
   logic         advance;
   logic         take;

   // Handshake control
   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      advance      = in_valid_ff && out_free;
      req_ready    = !in_valid_ff || advance;
      take         = req_valid && req_ready;
      in_valid_in  = take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   rapc_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .word_in  (in_word_ff),
      .word_out (step_word)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture input word, hold result word while stalled
   always_ff @(posedge clock) begin
      if (take) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff <= step_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   // A stalled input stage means the result stage is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stage stalled without a held result");

   // A good verdict only comes with the check byte
   a_good_on_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.packet_good) |-> rsp_data.check_seen)
      else $error("packet_good without check_seen");

   // Check byte and length byte are never the same word
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.check_seen && rsp_data.length_bad))
      else $error("check_seen and length_bad together");

   // A buffered word moves on in the next cycle when the result stage is empty
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("buffered word did not advance");

endmodule
